>>> hw/rtl/pbas_pkg.sv
package pbas_pkg;

  // Field widths of the command, result and configuration port.
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 16;
  localparam int END_W      = 17;
  localparam int VAL_W      = 32;
  localparam int WIDTH_W    = 6;
  localparam int COUNT_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Bit position of an element start (below 65536 * 32), word index and bit offset.
  localparam int POS_W  = 21;
  localparam int WIDX_W = 16;
  localparam int OFF_W  = 6;

  // Entries in the queue between front and back end; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'd1;

  // Register limits and reset values.
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 6'd32;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd8;
  localparam logic [COUNT_W-1:0] MAX_COUNT   = 17'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd0;

  // What the back end has to do with a classified command.
  typedef enum logic [1:0] {
    OP_RESP,
    OP_READ,
    OP_WRITE,
    OP_FILL
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic                 status;
    logic [WIDTH_W-1:0]   width;
    logic [POS_W-1:0]     pos;
    logic [COUNT_W-1:0]   count;
    logic [VAL_W-1:0]     value;
    logic [WIDX_W-1:0]    word;
    logic [OFF_W-1:0]     offset;
  } pbas_op_t;

  // Low w bits set; w is at most 32.
  function automatic logic [VAL_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [VAL_W:0] full;
    full = ((VAL_W+1)'(1) << w) - (VAL_W+1)'(1);
    return full[VAL_W-1:0];
  endfunction

endpackage

>>> hw/rtl/pbas_ifs.sv
// Command channel.
interface pbas_in_if;
  import pbas_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [IDX_W-1:0]   index;
  logic [END_W-1:0]   end_index;
  logic [VAL_W-1:0]   value;

  modport source(output valid, command, index, end_index, value, input ready);
  modport sink(input valid, command, index, end_index, value, output ready);
endinterface

// Result channel.
interface pbas_out_if;
  import pbas_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic               status;

  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

>>> hw/rtl/pbas_front.sv
module pbas_front #(
  parameter int WORD_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pbas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbas_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept_en,
  pbas_in_if.sink                         in_ch,
  output logic                            push_valid,
  input  logic                            push_ready,
  output pbas_pkg::pbas_op_t              push_op
);
  import pbas_pkg::*;

  // Bit counts are compared at 23 bits: the store holds at most 2^22 bits.
  localparam int TOTAL_W = 23;
  localparam logic [TOTAL_W-1:0] TOTAL_BITS = TOTAL_W'(WORD_COUNT * WORD_BITS);

  // Exact floor division of a bit position by WORD_BITS through a reciprocal.
  localparam int RECIP_SH = POS_W + 6;
  localparam int RECIP_W  = 23;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam int PROD_W = POS_W + RECIP_W;

  logic [WIDTH_W-1:0] width_r;
  logic [COUNT_W-1:0] count_r;
  logic               a_valid_r;
  logic               b_valid_r;
  pbas_op_t           a_r;
  pbas_op_t           b_r;

  logic [WIDTH_W-1:0] w_eff;
  logic [COUNT_W-1:0] n_eff;
  logic [END_W-1:0]   idx_ext;
  logic [TOTAL_W-1:0] start_bits;
  logic [TOTAL_W-1:0] stop_bits;
  logic [TOTAL_W-1:0] end_bits;
  logic               idx_bad;
  logic               rw_bad;
  logic               fill_bad;
  logic               fill_empty;
  pbas_op_t           op_in;
  logic               a_ready;
  logic               b_ready;
  logic [PROD_W-1:0]  prod;
  pbas_op_t           b_op;
  logic               in_xfer;

  // Register limits: larger values act as the maximum.
  assign w_eff = (width_r > MAX_WIDTH) ? MAX_WIDTH : width_r;
  assign n_eff = (count_r > MAX_COUNT) ? MAX_COUNT : count_r;

  // Bounds of the addressed element and of the fill range.
  assign idx_ext    = END_W'(in_ch.index);
  assign start_bits = TOTAL_W'(in_ch.index) * TOTAL_W'(w_eff);
  assign stop_bits  = start_bits + TOTAL_W'(w_eff);
  assign end_bits   = TOTAL_W'(in_ch.end_index) * TOTAL_W'(w_eff);
  assign idx_bad    = idx_ext >= n_eff;
  assign rw_bad     = idx_bad || (stop_bits > TOTAL_BITS);
  assign fill_bad   = idx_bad || (in_ch.end_index > n_eff) || (end_bits > TOTAL_BITS);
  assign fill_empty = idx_ext >= in_ch.end_index;

  // Classify the command; errors and no-op commands only need a response.
  always_comb begin
    op_in        = '0;
    op_in.width  = w_eff;
    op_in.pos    = start_bits[POS_W-1:0];
    op_in.count  = in_ch.end_index - idx_ext;
    op_in.value  = in_ch.value & width_mask(w_eff);
    op_in.kind   = OP_RESP;
    op_in.status = 1'b1;
    case (in_ch.command)
      CMD_READ, CMD_WRITE: begin
        if (!rw_bad) begin
          op_in.status = 1'b0;
          if (w_eff != '0) begin
            op_in.kind = (in_ch.command == CMD_READ) ? OP_READ : OP_WRITE;
          end
        end
      end
      CMD_FILL: begin
        if (!fill_bad) begin
          op_in.status = 1'b0;
          if ((w_eff != '0) && !fill_empty) begin
            op_in.kind = OP_FILL;
          end
        end
      end
      default: begin
        op_in.kind = OP_RESP;
      end
    endcase
  end

  // Two-stage pipeline: bounds check, then word index.
  assign b_ready     = !b_valid_r || push_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign in_ch.ready = accept_en && a_ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    prod      = PROD_W'(a_r.pos) * PROD_W'(RECIP);
    b_op      = a_r;
    b_op.word = prod[RECIP_SH +: WIDX_W];
  end

  // Bit offset within the word is what the word index leaves of the position.
  always_comb begin
    push_op        = b_r;
    push_op.offset = OFF_W'(b_r.pos - POS_W'(b_r.word * WORD_BITS));
  end
  assign push_valid = b_valid_r;

  // Configuration registers and stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      count_r   <= COUNT_RESET;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ELEMENT_WIDTH: width_r <= cfg_data[WIDTH_W-1:0];
          CFG_ELEMENT_COUNT: count_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (a_ready) begin
        a_valid_r <= in_xfer;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_r <= op_in;
    end
    if (b_ready && a_valid_r) begin
      b_r <= b_op;
    end
  end

endmodule

>>> hw/rtl/pbas_queue.sv
module pbas_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pbas_pkg::pbas_op_t push_op,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pbas_pkg::pbas_op_t pop_op
);
  import pbas_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W:0] FULL_LEVEL = (PTR_W+1)'(QUEUE_DEPTH);

  pbas_op_t         entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   level_r;
  logic             push_xfer;
  logic             pop_xfer;

  assign push_ready = level_r != FULL_LEVEL;
  assign pop_valid  = level_r != '0;
  assign pop_op     = entries_r[rd_ptr_r];
  assign push_xfer  = push_valid && push_ready;
  assign pop_xfer   = pop_valid && pop_ready;

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push_xfer) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop_xfer) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push_xfer && !pop_xfer) begin
        level_r <= level_r + (PTR_W+1)'(1);
      end else if (pop_xfer && !push_xfer) begin
        level_r <= level_r - (PTR_W+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_xfer) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> hw/rtl/pbas_back.sv
module pbas_back #(
  parameter int WORD_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               accept_en,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  pbas_pkg::pbas_op_t pop_op,
  pbas_out_if.source         out_ch
);
  import pbas_pkg::*;

  localparam int AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WIN_W = 2 * WORD_BITS;
  localparam logic [AW-1:0]  LAST_ADDR   = AW'(WORD_COUNT - 1);
  localparam logic [OFF_W:0] WORD_BITS_V = (OFF_W+1)'(WORD_BITS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_UPPER
  } state_t;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  state_t               state_r;
  state_t               state_nxt;
  logic [AW-1:0]        clr_addr_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 out_status_r;
  pbas_op_t             cur_r;
  logic [WORD_BITS-1:0] rd_lo_r;
  logic [WORD_BITS-1:0] rd_hi_r;

  logic [WIDX_W-1:0]    rd_word;
  logic [AW-1:0]        rd_addr_lo;
  logic [AW-1:0]        rd_addr_hi;
  logic                 out_free;
  logic [WIN_W-1:0]     win;
  logic [WIN_W-1:0]     shifted;
  logic [WIN_W-1:0]     mask_win;
  logic [WIN_W-1:0]     value_win;
  logic [WIN_W-1:0]     new_win;
  logic [VAL_W-1:0]     elem;
  logic [OFF_W:0]       off_sum;
  logic                 straddle;
  logic                 wrap;
  logic                 last_elem;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 out_load;
  logic [VAL_W-1:0]     out_value_nxt;
  logic                 out_status_nxt;
  logic                 step;

  // Words are read from the queue head at pop time and from the current op otherwise.
  assign rd_word    = (state_r == S_IDLE) ? pop_op.word : cur_r.word;
  assign rd_addr_lo = rd_word[AW-1:0];
  assign rd_addr_hi = (rd_addr_lo == LAST_ADDR) ? '0 : rd_addr_lo + AW'(1);

  assign out_free  = !out_valid_r || out_ch.ready;
  assign accept_en = state_r != S_CLEAR;

  // Two-word window around the element: extract for reads, merge for writes.
  assign win       = {rd_hi_r, rd_lo_r};
  assign shifted   = win >> cur_r.offset;
  assign elem      = shifted[VAL_W-1:0] & width_mask(cur_r.width);
  assign mask_win  = WIN_W'(width_mask(cur_r.width)) << cur_r.offset;
  assign value_win = WIN_W'(cur_r.value) << cur_r.offset;
  assign new_win   = (win & ~mask_win) | value_win;

  // Element placement and the position of the next fill element.
  assign off_sum   = {1'b0, cur_r.offset} + {1'b0, cur_r.width};
  assign straddle  = off_sum > WORD_BITS_V;
  assign wrap      = off_sum >= WORD_BITS_V;
  assign last_elem = (cur_r.kind != OP_FILL) || (cur_r.count == COUNT_W'(1));

  // Sequencer: clearing pass, pop, read, modify lower word, write upper word.
  always_comb begin
    state_nxt      = state_r;
    pop_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = rd_addr_lo;
    mem_wdata      = new_win[WORD_BITS-1:0];
    out_load       = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = 1'b0;
    step           = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_valid) begin
          if (pop_op.kind == OP_RESP) begin
            if (out_free) begin
              pop_ready      = 1'b1;
              out_load       = 1'b1;
              out_status_nxt = pop_op.status;
            end
          end else begin
            pop_ready = 1'b1;
            state_nxt = S_MODIFY;
          end
        end
      end
      S_READ: begin
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        if (cur_r.kind == OP_READ) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_value_nxt = elem;
            state_nxt     = S_IDLE;
          end
        end else if (straddle) begin
          mem_we    = 1'b1;
          state_nxt = S_UPPER;
        end else if (!last_elem) begin
          mem_we    = 1'b1;
          step      = 1'b1;
          state_nxt = S_READ;
        end else if (out_free) begin
          mem_we    = 1'b1;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_UPPER: begin
        mem_addr  = rd_addr_hi;
        mem_wdata = new_win[WIN_W-1:WORD_BITS];
        if (!last_elem) begin
          mem_we    = 1'b1;
          step      = 1'b1;
          state_nxt = S_READ;
        end else if (out_free) begin
          mem_we    = 1'b1;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, clearing address and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      out_value_r  <= '0;
      out_status_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= out_value_nxt;
        out_status_r <= out_status_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Current operation; a fill steps to the next element in place.
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_op;
    end else if (step) begin
      cur_r.count  <= cur_r.count - COUNT_W'(1);
      cur_r.offset <= wrap ? OFF_W'(off_sum - WORD_BITS_V) : OFF_W'(off_sum);
      cur_r.word   <= cur_r.word + WIDX_W'(wrap);
    end
  end

  // Memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) || (state_r == S_READ)) begin
      rd_lo_r <= mem[rd_addr_lo];
      rd_hi_r <= mem[rd_addr_hi];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.status     = out_status_r;

  // Every write lands inside the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_addr <= LAST_ADDR))
    else $error("memory write beyond the last word");

  // A straddling element never starts in the last word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPPER) |-> (rd_addr_lo != LAST_ADDR))
    else $error("straddling element starts in the last word");

  // Only a fill with elements left comes back to read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ((cur_r.kind == OP_FILL) && (cur_r.count != '0)))
    else $error("read step without a fill element pending");

  // No result is offered before the clearing pass is over.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result offered during the clearing pass");

endmodule

>>> hw/rtl/packed_bitfield_array_store.sv
// The back end finishes one command before it takes the next from the queue. An error or
// an empty command only needs a response; a read fetches its two words and returns the
// element; a write modifies the lower word and, for an element that straddles two words,
// also writes the upper word (one write port). A fill repeats the read and the write for every element.
// Reset: synchronous, active low; the store is then zeroed one word per cycle, during
// which no command transfer is accepted (configuration is).
module packed_bitfield_array_store #(
  parameter int WORD_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pbas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbas_pkg::CFG_DATA_W-1:0] cfg_data,
  pbas_in_if.sink                         in_ch,
  pbas_out_if.source                      out_ch
);
  import pbas_pkg::*;

  logic     accept_en;
  logic     push_valid;
  logic     push_ready;
  pbas_op_t push_op;
  logic     pop_valid;
  logic     pop_ready;
  pbas_op_t pop_op;

  // Front end: configuration, bounds checks and word placement.
  pbas_front #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept_en  (accept_en),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // Queue of classified commands.
  pbas_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Back end: word memory, read-modify-write and result register.
  pbas_back #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_en (accept_en),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/pbas_result_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels, keeps a shadow copy of the
// packed store and compares every result transfer with the predicted reply.
module pbas_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pbas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbas_pkg::CFG_DATA_W-1:0] cfg_data,
  pbas_in_if                              in_mon,
  pbas_out_if                             out_mon,
  output int                              error_count,
  output int                              outstanding
);
  import pbas_pkg::*;

  localparam int STORE_WORDS = 1024;
  localparam int WORD_BITS   = 64;
  localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } reply_t;

  logic [WORD_BITS-1:0] shadow_words [0:STORE_WORDS-1];
  logic [WIDTH_W-1:0]   width_reg;
  logic [COUNT_W-1:0]   count_reg;
  reply_t               expected_replies[$];
  int                   results_seen;

  // Extracts one element; the caller guarantees it lies inside the store and w > 0.
  function automatic logic [VAL_W-1:0] fetch_element(input int unsigned ix,
                                                     input int unsigned w);
    logic [31:0]          pos;
    int unsigned          wi;
    int unsigned          off;
    logic [WORD_BITS-1:0] bits;
    logic [WORD_BITS-1:0] m;
    pos  = ix * w;
    wi   = pos >> 6;
    off  = pos & 32'd63;
    bits = shadow_words[wi] >> off;
    // An element that runs past the word takes its upper bits from the next one.
    if (off + w > WORD_BITS)
      bits = bits | (shadow_words[wi + 1] << (WORD_BITS - off));
    m = (64'd1 << w) - 64'd1;
    return VAL_W'(bits & m);
  endfunction

  // Read-modify-write of the one or two words that hold an element.
  task automatic store_element(input int unsigned ix, input int unsigned w,
                               input logic [VAL_W-1:0] val);
    logic [31:0]          pos;
    int unsigned          wi;
    int unsigned          off;
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] v;
    pos = ix * w;
    wi  = pos >> 6;
    off = pos & 32'd63;
    m   = (64'd1 << w) - 64'd1;
    v   = {32'd0, val} & m;
    shadow_words[wi] = (shadow_words[wi] & ~(m << off)) | (v << off);
    if (off + w > WORD_BITS)
      shadow_words[wi + 1] = (shadow_words[wi + 1] & ~(m >> (WORD_BITS - off))) |
                             (v >> (WORD_BITS - off));
  endtask

  // Carries out one command on the shadow store and works out its reply.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [END_W-1:0] stop, input logic [VAL_W-1:0] val,
                               output reply_t reply);
    int unsigned w;
    int unsigned n;
    int unsigned ix;
    int unsigned last;
    int unsigned i;
    w     = (width_reg > MAX_WIDTH) ? 32 : width_reg;
    n     = (count_reg > MAX_COUNT) ? 65536 : count_reg;
    ix    = idx;
    last  = stop;
    reply = '0;
    case (cmd)
      CMD_READ, CMD_WRITE: begin
        if (ix >= n || (ix + 1) * w > STORE_BITS) begin
          reply.status = 1'b1;
        end else if (w != 0) begin
          if (cmd == CMD_READ)
            reply.read_value = fetch_element(ix, w);
          else
            store_element(ix, w, val);
        end
      end
      CMD_FILL: begin
        if (ix >= n || last > n || last * w > STORE_BITS) begin
          reply.status = 1'b1;
        end else if (w != 0) begin
          for (i = ix; i < last; i++)
            store_element(i, w, val);
        end
      end
      default: reply.status = 1'b1;
    endcase
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    reply_t predicted;
    reply_t expected;
    if (!rst_n) begin
      width_reg   = WIDTH_RESET;
      count_reg   = COUNT_RESET;
      error_count = 0;
      outstanding = 0;
      results_seen = 0;
      expected_replies.delete();
      for (int k = 0; k < STORE_WORDS; k++)
        shadow_words[k] = '0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == CFG_ELEMENT_WIDTH)
          width_reg = cfg_data[WIDTH_W-1:0];
        else if (cfg_index == CFG_ELEMENT_COUNT)
          count_reg = cfg_data[COUNT_W-1:0];
      end

      // Command transfer: predict its reply and queue it at the tail.
      if (in_mon.valid && in_mon.ready) begin
        apply_command(in_mon.command, in_mon.index, in_mon.end_index, in_mon.value,
                      predicted);
        expected_replies.insert(expected_replies.size(), predicted);
      end

      // Result transfer: compare with the oldest reply still waiting.
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: result %0d arrived with none expected (read_value %h, status %b)",
                     $time, results_seen, out_mon.read_value, out_mon.status);
        end else begin
          expected = expected_replies.pop_front();
          if (out_mon.read_value !== expected.read_value ||
              out_mon.status !== expected.status) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              if (out_mon.read_value !== expected.read_value)
                $display("%0t: result %0d read_value expected %h, got %h", $time,
                         results_seen, expected.read_value, out_mon.read_value);
              if (out_mon.status !== expected.status)
                $display("%0t: result %0d status expected %b, got %b", $time,
                         results_seen, expected.status, out_mon.status);
            end
          end
        end
      end

      outstanding = expected_replies.size();
    end
  end

endmodule

>>> sim/packed_bitfield_array_store_tb.sv
`timescale 1ns / 100ps

module packed_bitfield_array_store_tb;
  import pbas_pkg::*;

  // The one command code that the block does not define.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int SEGMENTS      = 16;
  localparam int SEGMENT_ITEMS = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int WINDOW_SPAN   = 64;
  localparam int MAX_FILL_RUN  = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          error_count;
  int          outstanding;
  int unsigned elem_limit;
  int unsigned win_lo;

  pbas_in_if  in_bus ();
  pbas_out_if out_bus ();

  packed_bitfield_array_store uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  pbas_result_checker result_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("packed_bitfield_array_store_tb: FAIL");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int held;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(negedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one command and returns at the falling edge after its transfer.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [END_W-1:0] stop, input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.index     <= idx;
    in_bus.end_index <= stop;
    in_bus.value     <= val;
    do
      @(posedge clk);
    while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every reply has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do
      @(negedge clk);
    while (outstanding != 0);
  endtask

  // Writes both registers back to back and works out how far indices stay valid.
  task automatic set_config(input logic [CFG_DATA_W-1:0] width_data,
                            input logic [CFG_DATA_W-1:0] count_data);
    int unsigned w;
    int unsigned n;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ELEMENT_WIDTH;
    cfg_data  <= width_data;
    @(negedge clk);
    cfg_index <= CFG_ELEMENT_COUNT;
    cfg_data  <= count_data;
    @(negedge clk);
    cfg_we <= 1'b0;
    w = (width_data[WIDTH_W-1:0] > MAX_WIDTH) ? 32 : width_data[WIDTH_W-1:0];
    n = (count_data > MAX_COUNT) ? 65536 : count_data;
    if (w != 0 && 65536 / w < n)
      elem_limit = 65536 / w;
    else
      elem_limit = n;
  endtask

  // One random command, mostly inside a small window so reads meet earlier writes.
  task automatic random_item();
    int unsigned      pick;
    int unsigned      ix;
    int unsigned      stop;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    ix   = win_lo + $urandom_range(0, WINDOW_SPAN - 1);
    if (ix >= elem_limit)
      ix = elem_limit - 1;
    stop = $urandom_range(0, 131071);
    if (pick < 40) begin
      cmd = CMD_READ;
    end else if (pick < 80) begin
      cmd = CMD_WRITE;
    end else if (pick < 94) begin
      cmd = CMD_FILL;
      // Mostly short runs; now and then an empty or an out-of-range one.
      case ($urandom_range(0, 9))
        0: stop = $urandom_range(0, ix);
        1: stop = $urandom_range(elem_limit + 1, 131071);
        default: begin
          stop = ix + $urandom_range(0, MAX_FILL_RUN);
          if (stop > elem_limit)
            stop = elem_limit;
        end
      endcase
    end else if (pick < 97) begin
      cmd = CMD_UNUSED;
    end else begin
      // Noise: any index at all.
      cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
      ix  = $urandom_range(0, 65535);
    end
    send_cmd(cmd, IDX_W'(ix), END_W'(stop), $urandom());
  endtask

  // Stimulus.
  initial begin
    logic [CFG_DATA_W-1:0] width_data;
    logic [CFG_DATA_W-1:0] count_data;
    int unsigned           w;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.command   = '0;
    in_bus.index     = '0;
    in_bus.end_index = '0;
    in_bus.value     = '0;
    send_idle_pct    = 10;
    recv_idle_pct    = 72;
    hold_req         = 1'b0;
    elem_limit       = 0;
    win_lo           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: no element is in use yet.
    send_cmd(CMD_READ, 16'd0, 17'd0, 32'hFFFF_FFFF);
    drain();

    // Widest elements over the whole store, and its last element.
    set_config(17'd32, 17'h10000);
    send_cmd(CMD_WRITE, 16'd0, 17'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 16'd0, 17'd0, 32'd0);
    send_cmd(CMD_WRITE, 16'd2047, 17'd0, 32'hA5A5_5A5A);
    send_cmd(CMD_READ, 16'd2047, 17'd0, 32'd0);
    send_cmd(CMD_READ, 16'd2048, 17'd0, 32'd0);
    send_cmd(CMD_WRITE, 16'hFFFF, 17'd0, 32'd1);
    send_cmd(CMD_FILL, 16'd0, 17'd2048, 32'h1234_5678);
    send_cmd(CMD_READ, 16'd1000, 17'd0, 32'd0);
    send_cmd(CMD_FILL, 16'd0, 17'd2049, 32'd7);
    send_cmd(CMD_UNUSED, 16'd3, 17'd5, 32'd9);
    drain();

    // Register values past their limits, with junk above the width field.
    set_config(17'h1_FFFF, 17'h1_FFFF);
    send_cmd(CMD_READ, 16'd5, 17'd0, 32'd0);
    drain();

    // Odd width: elements straddle words, writes are masked, fills have edge cases.
    set_config(17'd7, 17'd100);
    send_cmd(CMD_WRITE, 16'd9, 17'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 16'd9, 17'd0, 32'd0);
    send_cmd(CMD_READ, 16'd8, 17'd0, 32'd0);
    send_cmd(CMD_READ, 16'd10, 17'd0, 32'd0);
    send_cmd(CMD_WRITE, 16'd100, 17'd0, 32'd3);
    send_cmd(CMD_FILL, 16'd5, 17'd5, 32'd1);
    send_cmd(CMD_FILL, 16'd10, 17'd101, 32'd1);
    send_cmd(CMD_FILL, 16'd100, 17'd100, 32'd1);
    send_cmd(CMD_FILL, 16'd20, 17'd30, 32'h55);
    send_cmd(CMD_READ, 16'd27, 17'd0, 32'd0);
    drain();

    // Width zero stores nothing and reads zero.
    set_config(17'd0, 17'd10);
    send_cmd(CMD_READ, 16'd3, 17'd0, 32'd0);
    send_cmd(CMD_WRITE, 16'd3, 17'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_FILL, 16'd0, 17'd10, 32'hFFFF_FFFF);
    drain();

    // One-bit elements: a fill over every index there is.
    set_config(17'd1, 17'h10000);
    send_cmd(CMD_FILL, 16'd0, 17'h10000, 32'd1);
    send_cmd(CMD_READ, 16'hFFFF, 17'd0, 32'd0);
    drain();

    // Random segments, each with its own settings and idle pattern.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        send_idle_pct = 10;
        recv_idle_pct = 72;
      end else if (seg < 10) begin
        send_idle_pct = 72;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg % 8)
        0:       w = 32;
        1:       w = 1;
        2:       w = 0;
        3:       w = $urandom_range(33, 63);
        default: w = $urandom_range(2, 31);
      endcase
      width_data = {11'($urandom_range(0, 2047)), 6'(w)};
      case ($urandom_range(0, 3))
        0:       count_data = 17'h10000;
        1:       count_data = 17'($urandom_range(65537, 131071));
        default: count_data = 17'($urandom_range(1, 5000));
      endcase
      set_config(width_data, count_data);
      win_lo = $urandom_range(0, elem_limit - 1);
      // Hold the result side off long enough for the block to back up.
      if (seg == 10)
        hold_req = 1'b1;
      for (int k = 0; k < SEGMENT_ITEMS; k++)
        random_item();
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("packed_bitfield_array_store_tb: PASS");
    else
      $display("packed_bitfield_array_store_tb: FAIL");
    $finish;
  end

endmodule
